FILE: hdl/dap_pkg.sv
`default_nettype none

package dap_pkg;

    // Parse phase of the current string
    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_WHOLE = 2'd1,
        PH_FRAC  = 2'd2,
        PH_TRAIL = 2'd3
    } t_phase;

    localparam int AMOUNT_W = 63;
    localparam logic [AMOUNT_W-1:0] MAX_AMOUNT_RST = 63'd2100000000000000;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Powers of ten, constant table
    function automatic logic [63:0] pow10(input logic [4:0] n);
        logic [63:0] p;
        case (n)
            5'd0:    p = 64'd1;
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            5'd17:   p = 64'd100000000000000000;
            5'd18:   p = 64'd1000000000000000000;
            5'd19:   p = 64'd10000000000000000000;
            default: p = 64'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/decimal_amount_parser.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// text in   in         i_valid / o_stall    i_text_byte, i_is_last
// result    out        o_valid / i_stall    o_valid_res, o_amount
// config    in         i_max_amount_we      i_max_amount
//
// One byte is taken every cycle while o_stall is low. After its last byte is taken,
// a string passes the input register, parse/snapshot, multiply, add and compare.
// Sync active-low reset clears the parse state and loads the default maximum.
// Stalls move back through the stage valids; empty stages keep filling while
// the output waits.

module decimal_amount_parser #(
    parameter int FRACTION_DIGITS  = 8,
    parameter int MAX_WHOLE_DIGITS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [7:0]                    i_text_byte,
    input  wire logic                          i_is_last,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_valid_res,
    output logic [dap_pkg::AMOUNT_W-1:0]       o_amount,
    input  wire logic                          i_max_amount_we,
    input  wire logic [dap_pkg::AMOUNT_W-1:0]  i_max_amount
);

    localparam int WHOLE_W = $clog2(dap_pkg::pow10(5'(MAX_WHOLE_DIGITS)));
    localparam int FRAC_W  = $clog2(dap_pkg::pow10(5'(FRACTION_DIGITS)));
    localparam int WCNT_W  = $clog2(MAX_WHOLE_DIGITS + 2);
    localparam int FCNT_W  = $clog2(FRACTION_DIGITS + 1);
    localparam int PW_W    = WHOLE_W + FRAC_W;
    localparam int SUM_W   = 65;
    localparam logic [WCNT_W-1:0] WCNT_SAT = WCNT_W'(MAX_WHOLE_DIGITS + 1);
    localparam logic [WCNT_W-1:0] WCNT_MAX = WCNT_W'(MAX_WHOLE_DIGITS);
    localparam logic [FCNT_W-1:0] FCNT_MAX = FCNT_W'(FRACTION_DIGITS);
    localparam logic [FRAC_W-1:0] POW_F    = FRAC_W'(dap_pkg::pow10(5'(FRACTION_DIGITS)));

    // Stage enables, from the output back
    logic en_out, en_mul, en_dn, en_in;

    logic                          r_in_v;
    logic [7:0]                    r_in_byte;
    logic                          r_in_last;

    dap_pkg::t_phase               r_phase, n_phase;
    logic [WHOLE_W-1:0]            r_whole, n_whole;
    logic [WCNT_W-1:0]             r_wcnt, n_wcnt;
    logic [FRAC_W-1:0]             r_frac, n_frac;
    logic [FCNT_W-1:0]             r_fcnt, n_fcnt;
    logic                          r_failed, n_failed;
    logic                          r_seen, n_seen;

    logic                          r_dn_v;
    logic                          r_dn_ok;
    logic [WHOLE_W-1:0]            r_dn_whole;
    logic [FRAC_W-1:0]             r_dn_frac;
    logic [FCNT_W-1:0]             r_dn_fcnt;

    logic                          r_mul_v;
    logic                          r_mul_ok;
    logic [PW_W-1:0]               r_mul_w;
    logic [FRAC_W-1:0]             r_mul_f;

    logic                          r_out_v;
    logic                          r_out_ok;
    logic [dap_pkg::AMOUNT_W-1:0]  r_out_amt;
    logic [dap_pkg::AMOUNT_W-1:0]  r_max;

    assign en_out  = !r_out_v || !i_stall;
    assign en_mul  = !r_mul_v || en_out;
    assign en_dn   = !r_dn_v  || en_mul;
    assign en_in   = !r_in_v  || en_dn;
    assign o_stall = !en_in;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= dap_pkg::MAX_AMOUNT_RST;
        end else if (i_max_amount_we) begin
            r_max <= i_max_amount;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en_in) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in && i_valid) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_is_last;
        end
    end

    // Byte classification and parse step
    logic                is_nul, is_ws, is_dig, is_dot;
    dap_pkg::t_phase     ph_body;
    logic [WCNT_W-1:0]   wcnt_inc;
    logic [3:0]          digit;

    assign is_nul  = (r_in_byte == dap_pkg::CH_NUL);
    assign is_ws   = (r_in_byte == dap_pkg::CH_SPACE)
                  || (r_in_byte inside {[dap_pkg::CH_TAB:dap_pkg::CH_CR]});
    assign is_dig  = r_in_byte inside {[dap_pkg::CH_ZERO:dap_pkg::CH_NINE]};
    assign is_dot  = (r_in_byte == dap_pkg::CH_DOT);
    assign digit   = r_in_byte[3:0];
    assign ph_body = (r_phase == dap_pkg::PH_LEAD) ? dap_pkg::PH_WHOLE : r_phase;
    assign wcnt_inc = (r_wcnt < WCNT_SAT) ? r_wcnt + 1'b1 : r_wcnt;

    always_comb begin
        n_phase  = r_phase;
        n_whole  = r_whole;
        n_wcnt   = r_wcnt;
        n_frac   = r_frac;
        n_fcnt   = r_fcnt;
        n_failed = r_failed;
        n_seen   = r_seen;
        if (is_nul) begin
            n_failed = 1'b1;
        end else if (is_ws) begin
            if (r_phase != dap_pkg::PH_LEAD) begin
                n_phase = dap_pkg::PH_TRAIL;
            end
        end else begin
            n_seen = 1'b1;
            if (r_phase == dap_pkg::PH_TRAIL) begin
                // content after trailing whitespace
                n_failed = 1'b1;
            end else begin
                n_phase = ph_body;
                if (is_dig) begin
                    if (ph_body == dap_pkg::PH_WHOLE) begin
                        n_wcnt = wcnt_inc;
                        if (wcnt_inc > WCNT_MAX) begin
                            n_failed = 1'b1;
                        end else begin
                            n_whole = (r_whole << 3) + (r_whole << 1)
                                    + WHOLE_W'(digit);
                        end
                    end else begin
                        if (r_fcnt >= FCNT_MAX) begin
                            n_failed = 1'b1;
                        end else begin
                            n_fcnt = r_fcnt + 1'b1;
                            n_frac = (r_frac << 3) + (r_frac << 1)
                                   + FRAC_W'(digit);
                        end
                    end
                end else if (is_dot) begin
                    if (ph_body == dap_pkg::PH_FRAC) begin
                        n_failed = 1'b1;
                    end else begin
                        n_phase = dap_pkg::PH_FRAC;
                    end
                end else begin
                    n_failed = 1'b1;
                end
            end
        end
    end

    // Parse state; cleared after every last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (en_dn && r_in_v && r_in_last)) begin
            r_phase  <= dap_pkg::PH_LEAD;
            r_whole  <= '0;
            r_wcnt   <= '0;
            r_frac   <= '0;
            r_fcnt   <= '0;
            r_failed <= 1'b0;
            r_seen   <= 1'b0;
        end else if (en_dn && r_in_v) begin
            r_phase  <= n_phase;
            r_whole  <= n_whole;
            r_wcnt   <= n_wcnt;
            r_frac   <= n_frac;
            r_fcnt   <= n_fcnt;
            r_failed <= n_failed;
            r_seen   <= n_seen;
        end
    end

    // Snapshot of a finished string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dn_v <= 1'b0;
        end else if (en_dn) begin
            r_dn_v <= r_in_v && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_dn && r_in_v && r_in_last) begin
            r_dn_ok    <= !n_failed && n_seen;
            r_dn_whole <= n_whole;
            r_dn_frac  <= n_frac;
            r_dn_fcnt  <= n_fcnt;
        end
    end

    // Scaling products; the scaled fraction always fits the fraction width
    logic [FCNT_W-1:0]   gap;
    logic [FRAC_W-1:0]   pow_gap;
    logic [FRAC_W-1:0]   frac_prod;

    assign gap       = FCNT_MAX - r_dn_fcnt;
    assign pow_gap   = FRAC_W'(dap_pkg::pow10(5'(gap)));
    assign frac_prod = FRAC_W'(r_dn_frac * pow_gap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else if (en_mul) begin
            r_mul_v <= r_dn_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_mul && r_dn_v) begin
            r_mul_ok <= r_dn_ok;
            r_mul_w  <= r_dn_whole * POW_F;
            r_mul_f  <= frac_prod;
        end
    end

    // Sum, range check and result register
    logic [SUM_W-1:0] sum;
    logic             in_range;

    assign sum      = SUM_W'(r_mul_w) + SUM_W'(r_mul_f);
    assign in_range = (sum <= SUM_W'(r_max));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r_mul_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_mul_v) begin
            r_out_ok  <= r_mul_ok && in_range;
            r_out_amt <= (r_mul_ok && in_range) ? sum[dap_pkg::AMOUNT_W-1:0] : '0;
        end
    end

    assign o_valid     = r_out_v;
    assign o_valid_res = r_out_ok;
    assign o_amount    = r_out_amt;

endmodule

`default_nettype wire
